>>> hw/rtl/ptdc_pkg.sv
// Shared constants, codes and types of the point table with deduplication.
package ptdc_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int COORD_BITS = 32;

    typedef enum logic [2:0] {
        CMD_LOAD   = 3'd0,
        CMD_DEDUP  = 3'd1,
        CMD_RD_PT  = 3'd2,
        CMD_RD_MAP = 3'd3,
        CMD_RD_BND = 3'd4
    } cmd_t;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_PT,
        S_RD_MAP,
        S_P1_HEAD,
        S_P1_KEY,
        S_P1_SCAN,
        S_P1_MARK,
        S_P2_HEAD,
        S_P2_MOVE
    } state_t;

endpackage

>>> hw/rtl/point_table_dedup_compact.sv
// Point table: append, read, per-axis bounds and in-place duplicate removal.
//
// Usage: one item in, one result out. The input channel (in_valid/in_stall)
// carries a command with a point or an index; the output channel
// (out_valid/out_stall) carries the result item from a single output register.
// Load and bounds read finish in the accepting cycle and their result is
// registered. Point and remap reads first pass through a read state for the
// synchronous read of the point or remap memory, taking no new item meanwhile.
// Deduplicate walks the table in two passes over the point memory, whose
// single read port paces both: a marking pass (each point compared on x and y
// against every lower index) and a compaction pass that moves the kept points
// down and fills the remap memory.
// A new item is taken only when the block is idle and the output register is
// empty or being emptied in the same cycle; while the receiver stalls the
// result is held and in_stall stays high.
// Reset empties the table, clears the bounds and the remap span and drops any
// pending result. Memory contents are not cleared; nothing unwritten is read.
module point_table_dedup_compact
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [2:0]          cmd,
    input  logic signed [31:0]  coord_x,
    input  logic signed [31:0]  coord_y,
    input  logic signed [31:0]  coord_z,
    input  logic [9:0]          which_point,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [1:0]          status,
    output logic [10:0]         result_index,
    output logic                dropped,
    output logic signed [31:0]  out_x,
    output logic signed [31:0]  out_y,
    output logic signed [31:0]  out_z,
    output logic signed [31:0]  max_x,
    output logic signed [31:0]  max_y,
    output logic signed [31:0]  max_z,
    output logic [10:0]         point_count
);

    localparam int IW = ptdc_pkg::IDX_W;
    localparam int CW = ptdc_pkg::CNT_W;
    localparam int DW = ptdc_pkg::COORD_BITS;
    localparam int MP = ptdc_pkg::MAX_POINTS;

    // Memories
    logic [DW-1:0] x_mem [MP];
    logic [DW-1:0] y_mem [MP];
    logic [DW-1:0] z_mem [MP];
    logic          mark_mem [MP];
    logic [CW:0]   map_mem [MP];

    logic [IW-1:0] rd_addr;
    logic [DW-1:0] q_x, q_y, q_z;
    logic          q_mark;
    logic [CW:0]   q_map;

    logic          pt_we;
    logic [IW-1:0] pt_waddr;
    logic [DW-1:0] wx, wy, wz;
    logic          mark_we;
    logic [IW-1:0] mark_waddr;
    logic          mark_wdata;
    logic          map_we;
    logic [IW-1:0] map_waddr;
    logic [CW:0]   map_wdata;

    // Control and table state
    ptdc_pkg::state_t state_reg, state_next;
    logic [CW-1:0] i_reg, i_next, j_reg, j_next;
    logic [CW-1:0] kept_reg, kept_next, removed_reg, removed_next;
    logic [CW-1:0] held_reg, held_next, span_reg, span_next;
    logic          found_reg, found_next;
    logic [DW-1:0] key_x_reg, key_x_next, key_y_reg, key_y_next;
    logic signed [DW-1:0] mnx_reg, mnx_next, mny_reg, mny_next, mnz_reg, mnz_next;
    logic signed [DW-1:0] mxx_reg, mxx_next, mxy_reg, mxy_next, mxz_reg, mxz_next;

    // Output register
    logic          ov_reg, ov_next;
    logic [1:0]    st_reg, st_next;
    logic [CW-1:0] ri_reg, ri_next;
    logic          dr_reg, dr_next;
    logic signed [DW-1:0] ox_reg, ox_next, oy_reg, oy_next, oz_reg, oz_next;
    logic signed [DW-1:0] ax_reg, ax_next, ay_reg, ay_next, az_reg, az_next;
    logic [CW-1:0] pc_reg, pc_next;

    logic          out_free;
    logic          take;
    logic          first;
    logic          hit;

    // Synchronous memory ports
    always_ff @(posedge clk)
    begin
        q_x    <= x_mem[rd_addr];
        q_y    <= y_mem[rd_addr];
        q_z    <= z_mem[rd_addr];
        q_mark <= mark_mem[rd_addr];
        q_map  <= map_mem[rd_addr];
        if (pt_we)
        begin
            x_mem[pt_waddr] <= wx;
            y_mem[pt_waddr] <= wy;
            z_mem[pt_waddr] <= wz;
        end
        if (mark_we)
            mark_mem[mark_waddr] <= mark_wdata;
        if (map_we)
            map_mem[map_waddr] <= map_wdata;
    end

    // Hold the output item until taken
    assign out_free = !ov_reg || !out_stall;
    assign in_stall = (state_reg != ptdc_pkg::S_IDLE) || !out_free;
    assign take     = in_valid && !in_stall;
    assign first    = (held_reg == '0);
    assign hit      = (q_x == key_x_reg) && (q_y == key_y_reg);

    always_comb
    begin
        state_next   = state_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        kept_next    = kept_reg;
        removed_next = removed_reg;
        held_next    = held_reg;
        span_next    = span_reg;
        found_next   = found_reg;
        key_x_next   = key_x_reg;
        key_y_next   = key_y_reg;
        mnx_next = mnx_reg; mny_next = mny_reg; mnz_next = mnz_reg;
        mxx_next = mxx_reg; mxy_next = mxy_reg; mxz_next = mxz_reg;
        ov_next  = ov_reg && out_stall;
        st_next  = st_reg;  ri_next = ri_reg;  dr_next = dr_reg;
        ox_next  = ox_reg;  oy_next = oy_reg;  oz_next = oz_reg;
        ax_next  = ax_reg;  ay_next = ay_reg;  az_next = az_reg;
        pc_next  = pc_reg;
        rd_addr    = '0;
        pt_we      = 1'b0;
        pt_waddr   = held_reg[IW-1:0];
        wx = coord_x; wy = coord_y; wz = coord_z;
        mark_we    = 1'b0;
        mark_waddr = i_reg[IW-1:0];
        mark_wdata = found_reg;
        map_we     = 1'b0;
        map_waddr  = i_reg[IW-1:0];
        map_wdata  = '0;

        unique case (state_reg)
            ptdc_pkg::S_IDLE:
            begin
                rd_addr = which_point;
                if (take)
                begin
                    // Default result: zero fields, current count
                    st_next = ptdc_pkg::ST_OK; ri_next = '0; dr_next = 1'b0;
                    ox_next = '0; oy_next = '0; oz_next = '0;
                    ax_next = '0; ay_next = '0; az_next = '0;
                    pc_next = held_reg;
                    ov_next = 1'b1;
                    unique case (cmd)
                        ptdc_pkg::CMD_LOAD:
                        begin
                            if (held_reg < CW'(MP))
                            begin
                                pt_we = 1'b1;
                                if (first || coord_x < mnx_reg) mnx_next = coord_x;
                                if (first || coord_y < mny_reg) mny_next = coord_y;
                                if (first || coord_z < mnz_reg) mnz_next = coord_z;
                                if (first || coord_x > mxx_reg) mxx_next = coord_x;
                                if (first || coord_y > mxy_reg) mxy_next = coord_y;
                                if (first || coord_z > mxz_reg) mxz_next = coord_z;
                                held_next = held_reg + 1'b1;
                                ri_next   = held_reg;
                                pc_next   = held_reg + 1'b1;
                            end
                            else
                                st_next = ptdc_pkg::ST_FULL;
                        end
                        ptdc_pkg::CMD_DEDUP:
                        begin
                            ov_next    = 1'b0;
                            i_next     = '0;
                            state_next = ptdc_pkg::S_P1_HEAD;
                        end
                        ptdc_pkg::CMD_RD_PT:
                        begin
                            if (CW'(which_point) < held_reg)
                            begin
                                ov_next    = 1'b0;
                                state_next = ptdc_pkg::S_RD_PT;
                            end
                            else
                                st_next = ptdc_pkg::ST_RANGE;
                        end
                        ptdc_pkg::CMD_RD_MAP:
                        begin
                            if (CW'(which_point) < span_reg)
                            begin
                                ov_next    = 1'b0;
                                state_next = ptdc_pkg::S_RD_MAP;
                            end
                            else
                                st_next = ptdc_pkg::ST_RANGE;
                        end
                        ptdc_pkg::CMD_RD_BND:
                        begin
                            ox_next = mnx_reg; oy_next = mny_reg; oz_next = mnz_reg;
                            ax_next = mxx_reg; ay_next = mxy_reg; az_next = mxz_reg;
                        end
                        default: ;
                    endcase
                end
            end
            ptdc_pkg::S_RD_PT:
            begin
                ox_next = q_x; oy_next = q_y; oz_next = q_z;
                ov_next = 1'b1;
                state_next = ptdc_pkg::S_IDLE;
            end
            ptdc_pkg::S_RD_MAP:
            begin
                ri_next = q_map[CW-1:0];
                dr_next = q_map[CW];
                ov_next = 1'b1;
                state_next = ptdc_pkg::S_IDLE;
            end
            // Marking pass: fetch the key point
            ptdc_pkg::S_P1_HEAD:
            begin
                rd_addr = i_reg[IW-1:0];
                if (i_reg == held_reg)
                begin
                    i_next       = '0;
                    kept_next    = '0;
                    removed_next = '0;
                    state_next   = ptdc_pkg::S_P2_HEAD;
                end
                else
                    state_next = ptdc_pkg::S_P1_KEY;
            end
            ptdc_pkg::S_P1_KEY:
            begin
                key_x_next = q_x;
                key_y_next = q_y;
                found_next = 1'b0;
                j_next     = '0;
                rd_addr    = '0;
                if (i_reg == '0)
                    state_next = ptdc_pkg::S_P1_MARK;
                else
                    state_next = ptdc_pkg::S_P1_SCAN;
            end
            // Compare against every lower index, one read a cycle
            ptdc_pkg::S_P1_SCAN:
            begin
                found_next = found_reg || hit;
                if (j_reg + 1'b1 < i_reg)
                begin
                    j_next  = j_reg + 1'b1;
                    rd_addr = j_next[IW-1:0];
                end
                else
                    state_next = ptdc_pkg::S_P1_MARK;
            end
            ptdc_pkg::S_P1_MARK:
            begin
                mark_we    = 1'b1;
                i_next     = i_reg + 1'b1;
                state_next = ptdc_pkg::S_P1_HEAD;
            end
            // Compaction pass
            ptdc_pkg::S_P2_HEAD:
            begin
                rd_addr = i_reg[IW-1:0];
                if (i_reg == held_reg)
                begin
                    span_next = held_reg;
                    held_next = kept_reg;
                    st_next = ptdc_pkg::ST_OK; ri_next = removed_reg; dr_next = 1'b0;
                    ox_next = '0; oy_next = '0; oz_next = '0;
                    ax_next = '0; ay_next = '0; az_next = '0;
                    pc_next = kept_reg;
                    ov_next = 1'b1;
                    state_next = ptdc_pkg::S_IDLE;
                end
                else
                    state_next = ptdc_pkg::S_P2_MOVE;
            end
            ptdc_pkg::S_P2_MOVE:
            begin
                map_we = 1'b1;
                if (q_mark)
                begin
                    map_wdata    = {1'b1, {CW{1'b0}}};
                    removed_next = removed_reg + 1'b1;
                end
                else
                begin
                    map_wdata = {1'b0, kept_reg};
                    pt_we     = 1'b1;
                    pt_waddr  = kept_reg[IW-1:0];
                    wx = q_x; wy = q_y; wz = q_z;
                    kept_next = kept_reg + 1'b1;
                end
                i_next     = i_reg + 1'b1;
                state_next = ptdc_pkg::S_P2_HEAD;
            end
            default: state_next = ptdc_pkg::S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ptdc_pkg::S_IDLE;
            held_reg  <= '0;
            span_reg  <= '0;
            ov_reg    <= 1'b0;
            mnx_reg <= '0; mny_reg <= '0; mnz_reg <= '0;
            mxx_reg <= '0; mxy_reg <= '0; mxz_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            held_reg  <= held_next;
            span_reg  <= span_next;
            ov_reg    <= ov_next;
            mnx_reg <= mnx_next; mny_reg <= mny_next; mnz_reg <= mnz_next;
            mxx_reg <= mxx_next; mxy_reg <= mxy_next; mxz_reg <= mxz_next;
        end
    end

    // Payload and walk registers
    always_ff @(posedge clk)
    begin
        i_reg <= i_next; j_reg <= j_next;
        kept_reg <= kept_next; removed_reg <= removed_next;
        found_reg <= found_next;
        key_x_reg <= key_x_next; key_y_reg <= key_y_next;
        st_reg <= st_next; ri_reg <= ri_next; dr_reg <= dr_next;
        ox_reg <= ox_next; oy_reg <= oy_next; oz_reg <= oz_next;
        ax_reg <= ax_next; ay_reg <= ay_next; az_reg <= az_next;
        pc_reg <= pc_next;
    end

    assign out_valid    = ov_reg;
    assign status       = st_reg;
    assign result_index = ri_reg;
    assign dropped      = dr_reg;
    assign out_x        = ox_reg;
    assign out_y        = oy_reg;
    assign out_z        = oz_reg;
    assign max_x        = ax_reg;
    assign max_y        = ay_reg;
    assign max_z        = az_reg;
    assign point_count  = pc_reg;

endmodule
